FILE: rtl/core/plpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plpc_pkg;

  localparam int PAGES_DEF      = 16;
  localparam int CHUNK_BITS_DEF = 32;
  localparam int DATA_W         = 32;
  localparam int CMD_W          = 3;
  localparam int PIN_W          = 8;
  localparam int MAXP_W         = 5;
  localparam int APB_AW         = 2;
  localparam int APB_DW         = 32;

  localparam logic [PIN_W-1:0]  PIN_MAX  = 8'd255;
  localparam logic [MAXP_W-1:0] MAXP_RST = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_DIRTY   = 3'd3,
    CMD_COMMIT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_EXISTS  = 2'd1,
    STS_ABSENT  = 2'd2,
    STS_NO_ROOM = 2'd3
  } status_e;

  typedef enum logic {
    KIND_RESP = 1'b0,
    KIND_WB   = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_MISS,
    S_SCAN,
    S_EV,
    S_EVW,
    S_INS,
    S_CM,
    S_CMW,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] chunk;
    logic              hit;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/core/plpc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface plpc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [plpc_pkg::CMD_W-1:0]           command;
  logic [plpc_pkg::DATA_W-1:0]          chunk;

  modport source (output valid, output command, output chunk, input ready);
  modport sink   (input valid, input command, input chunk, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/plpc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface plpc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [plpc_pkg::DATA_W-1:0] chunk_out;
  logic                        hit;
  logic [1:0]                  status;
  logic                        last;

  modport source (output valid, output kind, output chunk_out, output hit, output status,
                  output last, input ready);
  modport sink   (input valid, input kind, input chunk_out, input hit, input status,
                  input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/plpc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module plpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/pinned_lru_page_cache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  fields
// in_i      sink       command, chunk
// out_o     source     kind, chunk_out, hit, status, last
// apb       slave      max_pages at byte address 0
//
// one item at a time; the tag search reads the tag ram in recency order, a read state
// and a compare state per entry up to the match; an eviction adds a scan for the least
// recent unpinned entry, the eviction itself and, if the entry is dirty, a write-back
// tags live in one single-port ram with registered read; the ram port sets the rate
// reset clears recency order, pins, dirty marks and entry count at once, no sweep
// a stalled output holds the sequencer only when a further item must be produced
module pinned_lru_page_cache_unit #(
  parameter int PAGES      = plpc_pkg::PAGES_DEF,
  parameter int CHUNK_BITS = plpc_pkg::CHUNK_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  plpc_in_if.sink                          in_i,
  plpc_out_if.source                       out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [plpc_pkg::APB_AW-1:0] paddr,
  input  wire logic [plpc_pkg::APB_DW-1:0] pwdata,
  output logic      [plpc_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import plpc_pkg::*;

  localparam int PW = $clog2(PAGES);
  localparam int CW = $clog2(PAGES + 1);
  localparam int TW = CHUNK_BITS;

  state_e state_q, state_d;

  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [TW-1:0]     chunk_q, chunk_d;
  logic [CW-1:0]     p_q, p_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     order_q [PAGES];
  logic [PW-1:0]     order_d [PAGES];
  logic [PIN_W-1:0]  pin_q [PAGES];
  logic [PIN_W-1:0]  pin_d [PAGES];
  logic [PAGES-1:0]  dirty_q, dirty_d;
  logic              ins_pre_q, ins_pre_d;
  logic [MAXP_W-1:0] maxp_q;
  res_t              pend_q, pend_d, out_q, out_d;
  logic              pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_addr;
  logic [TW-1:0]     ram_rdata;

  logic [PW-1:0]     pidx, cidx, ps, cs;
  logic              match, can_push, in_fire, out_free;
  logic [7:0]        lim8;
  logic              ins_over, rem_over;
  logic [TW-1:0]     in_tag;
  logic [DATA_W-1:0] in_back, chunk_back, rdata_back;
  logic              push;
  res_t              push_item;

  plpc_ram #(.WIDTH(TW), .DEPTH(PAGES)) u_tags (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(chunk_q),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < TW; i++) begin
      in_tag[i] = (i < DATA_W) ? in_i.chunk[i % DATA_W] : 1'b0;
    end
    for (int i = 0; i < DATA_W; i++) begin
      in_back[i]    = (i < TW) ? in_tag[i % TW] : 1'b0;
      chunk_back[i] = (i < TW) ? chunk_q[i % TW] : 1'b0;
      rdata_back[i] = (i < TW) ? ram_rdata[i % TW] : 1'b0;
    end
  end

  assign pidx     = p_q[PW-1:0];
  assign cidx     = cnt_q[PW-1:0];
  assign ps       = order_q[pidx];
  assign cs       = order_q[cidx];
  assign match    = (ram_rdata == chunk_q);
  assign out_free = !out_v_q || out_o.ready;
  assign can_push = !pend_v_q || out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign lim8     = ({3'b000, maxp_q} > 8'(PAGES)) ? 8'(PAGES) : {3'b000, maxp_q};
  assign ins_over = (8'(cnt_q) + 8'd1) > lim8;
  assign rem_over = (8'(cnt_q) - 8'd1) > lim8;

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = out_v_q;
  assign out_o.kind      = out_q.kind;
  assign out_o.chunk_out = out_q.chunk;
  assign out_o.hit       = out_q.hit;
  assign out_o.status    = out_q.status;
  assign out_o.last      = out_q.last;

  assign pready = 1'b1;
  assign prdata = {{(APB_DW-MAXP_W){1'b0}}, maxp_q};

  // single register, paddr is not decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxp_q <= MAXP_RST;
    end else if (psel && penable && pwrite) begin
      maxp_q <= pwdata[MAXP_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.command == CMD_COMMIT) state_d = S_CM;
          else if (in_i.command > CMD_COMMIT) state_d = S_FLUSH;
          else state_d = S_RD;
        end
      end
      S_RD:  state_d = (p_q >= cnt_q) ? S_MISS : S_CMP;
      S_CMP: state_d = match ? S_FLUSH : S_RD;
      S_MISS: begin
        if (cmd_q == CMD_READ || cmd_q == CMD_CREATE) begin
          state_d = (cnt_q == CW'(PAGES)) ? S_SCAN : S_INS;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_SCAN: begin
        if (pin_q[ps] == '0) state_d = S_EV;
        else if (p_q == '0) state_d = S_FLUSH;
      end
      S_EV: begin
        if (dirty_q[ps]) state_d = S_EVW;
        else if (ins_pre_q) state_d = S_INS;
        else state_d = rem_over ? S_SCAN : S_FLUSH;
      end
      S_EVW: begin
        if (can_push) begin
          if (ins_pre_q) state_d = S_INS;
          else state_d = rem_over ? S_SCAN : S_FLUSH;
        end
      end
      S_INS: state_d = ins_over ? S_SCAN : S_FLUSH;
      S_CM: begin
        if (p_q >= cnt_q) state_d = S_FLUSH;
        else if (dirty_q[ps]) state_d = S_CMW;
      end
      S_CMW:   if (can_push) state_d = S_CM;
      S_FLUSH: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic remove;
    remove    = 1'b0;
    cmd_d     = cmd_q;
    chunk_d   = chunk_q;
    p_d       = p_q;
    cnt_d     = cnt_q;
    order_d   = order_q;
    pin_d     = pin_q;
    dirty_d   = dirty_q;
    ins_pre_d = ins_pre_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = ps;
    push      = 1'b0;
    push_item = '{kind: KIND_RESP, chunk: chunk_back, hit: 1'b0, status: STS_OK, last: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d   = in_i.command;
          chunk_d = in_tag;
          p_d     = '0;
          if (in_i.command == CMD_COMMIT) begin
            push            = 1'b1;
            push_item.chunk = '0;
          end else if (in_i.command > CMD_COMMIT) begin
            push            = 1'b1;
            push_item.chunk = in_back;
          end
        end
      end
      S_RD: begin
        if (p_q < cnt_q) ram_re = 1'b1;
      end
      S_CMP: begin
        if (match) begin
          push = 1'b1;
          case (cmd_q)
            CMD_READ: begin
              push_item.hit = 1'b1;
              if (pin_q[ps] != PIN_MAX) pin_d[ps] = pin_q[ps] + PIN_W'(1);
              for (int q = 0; q < PAGES; q++) begin
                if (q == 0) order_d[q] = ps;
                else if (CW'(q) <= p_q) order_d[q] = order_q[(q + PAGES - 1) % PAGES];
              end
            end
            CMD_CREATE: push_item.status = STS_EXISTS;
            CMD_RELEASE: begin
              if (pin_q[ps] != '0) pin_d[ps] = pin_q[ps] - PIN_W'(1);
            end
            default: dirty_d[ps] = 1'b1;
          endcase
        end else begin
          p_d = p_q + CW'(1);
        end
      end
      S_MISS: begin
        if (cmd_q == CMD_READ || cmd_q == CMD_CREATE) begin
          if (cnt_q == CW'(PAGES)) begin
            p_d       = cnt_q - CW'(1);
            ins_pre_d = 1'b1;
          end else begin
            push      = 1'b1;
            ins_pre_d = 1'b0;
          end
        end else begin
          push             = 1'b1;
          push_item.status = STS_ABSENT;
        end
      end
      S_SCAN: begin
        if (pin_q[ps] == '0) begin
          push = ins_pre_q;
        end else if (p_q == '0) begin
          push             = ins_pre_q;
          push_item.status = STS_NO_ROOM;
        end else begin
          p_d = p_q - CW'(1);
        end
      end
      S_EV: begin
        if (dirty_q[ps]) ram_re = 1'b1;
        else remove = 1'b1;
      end
      S_EVW: begin
        if (can_push) begin
          push            = 1'b1;
          push_item.kind  = KIND_WB;
          push_item.chunk = rdata_back;
          remove          = 1'b1;
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_addr  = cs;
        pin_d[cs] = PIN_W'(1);
        dirty_d[cs] = (cmd_q == CMD_CREATE);
        for (int q = 0; q < PAGES; q++) begin
          if (q == 0) order_d[q] = cs;
          else if (CW'(q) <= cnt_q) order_d[q] = order_q[(q + PAGES - 1) % PAGES];
        end
        cnt_d     = cnt_q + CW'(1);
        p_d       = cnt_q;
        ins_pre_d = 1'b0;
      end
      S_CM: begin
        if (p_q < cnt_q) begin
          if (dirty_q[ps]) ram_re = 1'b1;
          else p_d = p_q + CW'(1);
        end
      end
      S_CMW: begin
        if (can_push) begin
          push            = 1'b1;
          push_item.kind  = KIND_WB;
          push_item.chunk = rdata_back;
          dirty_d[ps]     = 1'b0;
          p_d             = p_q + CW'(1);
        end
      end
      S_FLUSH: ;
      default: ;
    endcase

    if (remove) begin
      for (int q = 0; q < PAGES; q++) begin
        if (CW'(q) >= p_q && CW'(q + 1) < cnt_q) order_d[q] = order_q[(q + 1) % PAGES];
        else if (CW'(q + 1) == cnt_q) order_d[q] = ps;
      end
      dirty_d[ps] = 1'b0;
      cnt_d       = cnt_q - CW'(1);
      p_d         = cnt_q - CW'(2);
    end

    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q;
    if (out_v_q && out_o.ready) out_v_d = 1'b0;
    if (push) begin
      if (pend_v_q) begin
        out_d      = pend_q;
        out_d.last = 1'b0;
        out_v_d    = 1'b1;
      end
      pend_d   = push_item;
      pend_v_d = 1'b1;
    end
    if (state_q == S_FLUSH && out_free) begin
      out_d      = pend_q;
      out_d.last = 1'b1;
      out_v_d    = 1'b1;
      pend_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_q       <= '0;
      cnt_q     <= '0;
      dirty_q   <= '0;
      ins_pre_q <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      for (int i = 0; i < PAGES; i++) begin
        order_q[i] <= PW'(i);
        pin_q[i]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      cnt_q     <= cnt_d;
      dirty_q   <= dirty_d;
      ins_pre_q <= ins_pre_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      order_q   <= order_d;
      pin_q     <= pin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    chunk_q <= chunk_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end
endmodule
`default_nettype wire

FILE: verif/tb_pinned_lru_page_cache_unit.sv
`timescale 1ns / 1ps
module tb_pinned_lru_page_cache_unit;
  import plpc_pkg::*;

  localparam int NPG = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  plpc_in_if  in_ch();
  plpc_out_if out_ch();

  pinned_lru_page_cache_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  // cache shadow
  logic [31:0] pg_tag [NPG];
  logic        pg_vld [NPG];
  logic [7:0]  pg_pin [NPG];
  logic        pg_dty [NPG];
  int          lru_ord [NPG];
  int          n_res;
  int          lim_pages;

  res_t expected_q[$];
  int   errors = 0;
  bit   rx_stall_en = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.chunk = '0;
    out_ch.ready = 1'b0;
  end

  function automatic void push_res(logic k, logic [31:0] c, logic h, logic [1:0] s);
    res_t r;
    r.kind = k; r.chunk = c; r.hit = h; r.status = s; r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NPG; i++) begin
      pg_tag[i] = '0; pg_vld[i] = 0; pg_pin[i] = 0; pg_dty[i] = 0; lru_ord[i] = i;
    end
    n_res = 0;
    lim_pages = 16;
  endfunction

  function automatic int find_chunk(logic [31:0] c);
    for (int p = 0; p < n_res; p++)
      if (pg_vld[lru_ord[p]] && pg_tag[lru_ord[p]] == c) return p;
    return -1;
  endfunction

  function automatic void move_front(int p);
    int s;
    s = lru_ord[p];
    for (int q = p; q > 0; q--) lru_ord[q] = lru_ord[q-1];
    lru_ord[0] = s;
  endfunction

  function automatic bit evict_lru();
    int s;
    for (int p = n_res - 1; p >= 0; p--) begin
      s = lru_ord[p];
      if (pg_pin[s] == 0) begin
        for (int q = p; q + 1 < n_res; q++) lru_ord[q] = lru_ord[q+1];
        lru_ord[n_res-1] = s;
        n_res--;
        pg_vld[s] = 0;
        if (pg_dty[s]) begin
          pg_dty[s] = 0;
          push_res(KIND_WB, pg_tag[s], 1'b0, STS_OK);
        end
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit insert_page(logic [31:0] c, bit d);
    int s, lim;
    if (n_res >= NPG && !evict_lru()) return 0;
    s = lru_ord[n_res];
    pg_tag[s] = c; pg_vld[s] = 1; pg_pin[s] = 1; pg_dty[s] = d;
    move_front(n_res);
    n_res++;
    lim = lim_pages > NPG ? NPG : lim_pages;
    while (n_res > lim && evict_lru()) ;
    return 1;
  endfunction

  function automatic void predict_cache(logic [2:0] cmd, logic [31:0] c);
    res_t rsp;
    int p, s, head, idx;
    logic h;
    logic [1:0] st;
    logic [31:0] rc;
    h = 0; st = STS_OK; rc = c;
    head = expected_q.size();
    rsp = '0;
    expected_q.push_back(rsp);
    case (cmd)
      CMD_READ: begin
        p = find_chunk(c);
        if (p >= 0) begin
          s = lru_ord[p];
          move_front(p);
          if (pg_pin[s] != PIN_MAX) pg_pin[s]++;
          h = 1;
        end else if (!insert_page(c, 0)) st = STS_NO_ROOM;
      end
      CMD_CREATE: begin
        if (find_chunk(c) >= 0) st = STS_EXISTS;
        else if (!insert_page(c, 1)) st = STS_NO_ROOM;
      end
      CMD_RELEASE, CMD_DIRTY: begin
        p = find_chunk(c);
        if (p < 0) st = STS_ABSENT;
        else begin
          s = lru_ord[p];
          if (cmd == CMD_RELEASE) begin
            if (pg_pin[s] != 0) pg_pin[s]--;
          end else pg_dty[s] = 1;
        end
      end
      CMD_COMMIT: begin
        rc = '0;
        for (int q = 0; q < n_res; q++) begin
          s = lru_ord[q];
          if (pg_vld[s] && pg_dty[s]) begin
            pg_dty[s] = 0;
            push_res(KIND_WB, pg_tag[s], 1'b0, STS_OK);
          end
        end
      end
      default: ;
    endcase
    rsp.kind = KIND_RESP; rsp.chunk = rc; rsp.hit = h; rsp.status = st; rsp.last = 0;
    expected_q[head] = rsp;
    idx = expected_q.size() - 1;
    expected_q[idx].last = 1'b1;
  endfunction

  task automatic send_item(logic [2:0] cmd, logic [31:0] c);
    repeat ($urandom_range(0, 16) * ($urandom_range(0, 3) != 0)) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.chunk = c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_cache(cmd, c);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_q.size() != 0) begin
      $display("FAIL");
      $finish;
    end
    repeat (80) @(negedge clk_i);
  endtask

  task automatic write_max_pages(int v);
    drain_results();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= v; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    lim_pages = v & 31;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected item kind=%0d chunk=%h", $time, out_ch.kind, out_ch.chunk_out);
        errors++;
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (out_ch.kind !== e.kind || out_ch.chunk_out !== e.chunk || out_ch.hit !== e.hit ||
            out_ch.status !== e.status || out_ch.last !== e.last) begin
          $display("%0t mismatch exp k=%0d c=%h h=%0d s=%0d l=%0d act k=%0d c=%h h=%0d s=%0d l=%0d",
                   $time, e.kind, e.chunk, e.hit, e.status, e.last, out_ch.kind,
                   out_ch.chunk_out, out_ch.hit, out_ch.status, out_ch.last);
          errors++;
        end
      end
    end
  end

  // sink side stalls
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      w = (rx_stall_en && $urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task automatic test_directed();
    send_item(CMD_READ, 32'h0000_0000);
    send_item(CMD_READ, 32'hFFFF_FFFF);
    send_item(CMD_READ, 32'hFFFF_FFFF);
    send_item(CMD_CREATE, 32'hFFFF_FFFF);
    send_item(CMD_CREATE, 32'hA5A5_5A5A);
    send_item(CMD_DIRTY, 32'h0000_0000);
    send_item(CMD_DIRTY, 32'h1234_5678);
    send_item(CMD_RELEASE, 32'h1234_5678);
    send_item(CMD_RELEASE, 32'h0000_0000);
    send_item(CMD_RELEASE, 32'h0000_0000);
    send_item(CMD_COMMIT, 32'hDEAD_BEEF);
    send_item(3'd5, 32'h5555_AAAA);
    send_item(3'd7, 32'hAAAA_5555);
    send_item(3'd6, 32'h0F0F_F0F0);
    drain_results();
  endtask

  task automatic test_pin_saturation();
    for (int i = 0; i < 257; i++) send_item(CMD_READ, 32'h0000_0077);
    send_item(CMD_RELEASE, 32'h0000_0077);
    drain_results();
  endtask

  task automatic test_full_pinned();
    write_max_pages(16);
    for (int i = 0; i < 18; i++) send_item(CMD_CREATE, 32'h100 + i);
    send_item(CMD_READ, 32'h200);
    for (int i = 0; i < 18; i++) send_item(CMD_RELEASE, 32'h100 + i);
    send_item(CMD_RELEASE, 32'hFFFF_FFFF);
    send_item(CMD_RELEASE, 32'h0000_0000);
    send_item(CMD_RELEASE, 32'h0000_0077);
    send_item(CMD_READ, 32'h300);
    send_item(CMD_COMMIT, 32'h0);
  endtask

  task automatic test_random(int n_items, int pool);
    logic [2:0] cmd;
    logic [31:0] c;
    for (int i = 0; i < n_items; i++) begin
      c = ($urandom_range(0, 9) == 0) ? $urandom() : 32'hC000_0000 + $urandom_range(0, pool);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: cmd = CMD_READ;
        6, 7, 8: cmd = CMD_CREATE;
        9, 10, 11, 12, 13, 14: cmd = CMD_RELEASE;
        15, 16: cmd = CMD_DIRTY;
        17, 18: cmd = CMD_COMMIT;
        default: cmd = 3'($urandom_range(5, 7));
      endcase
      send_item(cmd, c);
      if (i == n_items / 2) drain_results();
    end
  endtask

  initial begin
    shadow_reset();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    test_directed();
    test_pin_saturation();
    test_full_pinned();
    write_max_pages(0);
    test_random(5, 12);
    write_max_pages(1);
    test_random(5, 8);
    write_max_pages(31);
    rx_stall_en = 1'b0;
    test_random(5, 30);
    rx_stall_en = 1'b1;
    write_max_pages(4);
    test_random(6, 10);
    write_max_pages(16);
    test_random(8, 24);
    drain_results();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: pinned_lru_page_cache_unit.f
rtl/core/plpc_pkg.sv
rtl/core/plpc_in_if.sv
rtl/core/plpc_out_if.sv
rtl/core/plpc_ram.sv
rtl/core/pinned_lru_page_cache_unit.sv
verif/tb_pinned_lru_page_cache_unit.sv
